[hw/rtl/fwamp_pkg.sv]
`timescale 1ns / 1ps

package fwamp_pkg;

    // Number of hex digits that the arithmetic keeps.
    localparam int DIGITS = 16;

    // Port width of every operand and result.
    localparam int VAL_W = 64;

    // Width of the arithmetic in bits.
    localparam int DATA_W = 4 * DIGITS;

    // The multiplier consumes one byte of its second operand per cycle.
    localparam int DIGIT_W = 8;

    // Width of the exponent field.
    localparam int EXP_W = 31;

    // Width of the opcode field.
    localparam int OPC_W = 2;

    // Mask that keeps the low DIGITS hex digits of a value.
    localparam logic [VAL_W-1:0] DIGIT_MASK =
        (DATA_W >= VAL_W) ? {VAL_W{1'b1}} : ((VAL_W'(1) << DATA_W) - VAL_W'(1));

    // Operation codes.
    localparam logic [OPC_W-1:0] OP_ADD = 2'd0;
    localparam logic [OPC_W-1:0] OP_MUL = 2'd1;
    localparam logic [OPC_W-1:0] OP_POW = 2'd2;

    // Request to the serial multiply-add unit: result is acc + x * y.
    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        logic [VAL_W-1:0] acc;
    } t_mul_req;

endpackage

[hw/rtl/fixed_width_add_mul_pow.sv]
`timescale 1ns / 1ps

// Modular add, multiply and power on DIGITS hex digits; results wrap modulo
// 16^DIGITS. An item is taken at a rising edge where start is high and busy
// is low; for add, multiply and power busy then stays high until the result
// has been produced. The result appears on o_result_value with o_valid high
// for exactly one cycle; the receiver cannot stall it, so it must take it in
// that cycle. All arithmetic runs through one serial multiply-add unit that
// consumes one byte of its second operand per cycle and stops once no bytes
// remain. Add is done on the same unit as a + b * 1. Add and multiply pass
// through the result register once the unit is done.
// Power uses square-and-multiply: per exponent bit a decision step, an
// optional multiply and a square; the top bit needs no square. The power
// result also passes through the result register. Exponent zero gives one,
// an unused opcode gives zero in the cycle after acceptance. Busy holds off
// the next item until the current one is done. Reset returns the sequencer
// to idle and drops any item in flight; no result is produced for it.
module fixed_width_add_mul_pow (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fwamp_pkg::OPC_W-1:0]  i_opcode,
    input  logic [fwamp_pkg::VAL_W-1:0]  i_first_operand,
    input  logic [fwamp_pkg::VAL_W-1:0]  i_second_operand,
    input  logic [fwamp_pkg::EXP_W-1:0]  i_exponent,
    output logic                         o_valid,
    output logic [fwamp_pkg::VAL_W-1:0]  o_result_value
);
    import fwamp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ARITH = 3'd1;
    localparam logic [2:0] ST_PSTEP = 3'd2;
    localparam logic [2:0] ST_PMUL  = 3'd3;
    localparam logic [2:0] ST_PSQR  = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [VAL_W-1:0] r_acc;
    logic [VAL_W-1:0] n_acc;
    logic [VAL_W-1:0] r_base;
    logic [VAL_W-1:0] n_base;
    logic [EXP_W-1:0] r_exp;
    logic [EXP_W-1:0] n_exp;
    logic             r_valid;
    logic             n_valid;
    logic [VAL_W-1:0] r_result;
    logic [VAL_W-1:0] n_result;

    logic [VAL_W-1:0] w_a;
    logic [VAL_W-1:0] w_b;
    t_mul_req         w_req;
    logic             w_done;
    logic [VAL_W-1:0] w_prod;

    // Operands reduced to DIGITS hex digits.
    assign w_a = i_first_operand & DIGIT_MASK;
    assign w_b = i_second_operand & DIGIT_MASK;

    fwamp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    // Sequencer for the three operations.
    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_base    = r_base;
        n_exp     = r_exp;
        n_valid   = 1'b0;
        n_result  = r_result;
        w_req     = '0;
        w_req.x   = r_acc;
        w_req.y   = r_base;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_opcode)
                        OP_ADD: begin
                            w_req.start = 1'b1;
                            w_req.x     = w_b;
                            w_req.y     = VAL_W'(1);
                            w_req.acc   = w_a;
                            n_state     = ST_ARITH;
                        end
                        OP_MUL: begin
                            w_req.start = 1'b1;
                            w_req.x     = w_a;
                            w_req.y     = w_b;
                            n_state     = ST_ARITH;
                        end
                        OP_POW: begin
                            n_acc   = VAL_W'(1);
                            n_base  = w_a;
                            n_exp   = i_exponent;
                            n_state = ST_PSTEP;
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_result = '0;
                        end
                    endcase
                end
            end
            ST_ARITH: begin
                if (w_done) begin
                    n_valid  = 1'b1;
                    n_result = w_prod & DIGIT_MASK;
                    n_state  = ST_IDLE;
                end
            end
            ST_PSTEP: begin
                // Decide on the current exponent bit.
                if (r_exp == '0) begin
                    n_valid  = 1'b1;
                    n_result = r_acc & DIGIT_MASK;
                    n_state  = ST_IDLE;
                end else if (r_exp[0]) begin
                    w_req.start = 1'b1;
                    n_state     = ST_PMUL;
                end else begin
                    w_req.start = 1'b1;
                    w_req.x     = r_base;
                    n_state     = ST_PSQR;
                end
            end
            ST_PMUL: begin
                if (w_done) begin
                    n_acc = w_prod;
                    // No higher exponent bits: the product is the answer.
                    if (r_exp[EXP_W-1:1] == '0) begin
                        n_valid  = 1'b1;
                        n_result = w_prod & DIGIT_MASK;
                        n_state  = ST_IDLE;
                    end else begin
                        w_req.start = 1'b1;
                        w_req.x     = r_base;
                        n_state     = ST_PSQR;
                    end
                end
            end
            ST_PSQR: begin
                if (w_done) begin
                    n_base  = w_prod;
                    n_exp   = r_exp >> 1;
                    n_state = ST_PSTEP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Working values and the result register.
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_base   <= n_base;
        r_exp    <= n_exp;
        r_result <= n_result;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_result_value = r_result;

endmodule

[hw/rtl/fwamp_mul.sv]
`timescale 1ns / 1ps

module fwamp_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fwamp_pkg::t_mul_req          i_req,
    output logic                         o_done,
    output logic [fwamp_pkg::VAL_W-1:0]  o_prod
);
    import fwamp_pkg::*;

    logic             r_busy;
    logic [VAL_W-1:0] r_x;
    logic [VAL_W-1:0] r_y;
    logic [VAL_W-1:0] r_acc;
    logic [VAL_W-1:0] w_pp;
    logic [VAL_W-1:0] n_acc;

    // One partial product per cycle: x times the lowest byte of y.
    assign w_pp  = r_x * VAL_W'(r_y[DIGIT_W-1:0]);
    assign n_acc = r_acc + w_pp;

    // The last step is the one after which no bytes of y remain.
    assign o_done = r_busy && (r_y[VAL_W-1:DIGIT_W] == '0);
    assign o_prod = n_acc;

    // Busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // Shift registers for the operands, and the running sum.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.x;
            r_y   <= i_req.y;
            r_acc <= i_req.acc;
        end else if (r_busy) begin
            r_x   <= r_x << DIGIT_W;
            r_y   <= r_y >> DIGIT_W;
            r_acc <= n_acc;
        end
    end

endmodule
